/* design/prot_pkg.sv */
// shared types and constants for the point rotation pipeline
`default_nettype none
package prot_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W         = 32;
	localparam int ROT_W           = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int AXIS_W          = 3;

	localparam logic [ROT_W-1:0] ROT_RESET = 64'h4000_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_ROT_X    = 3'd3,
		REG_ROT_Y    = 3'd4,
		REG_ROT_Z    = 3'd5,
		REG_AXIS_EN  = 3'd6
	} cfg_reg_t;

	localparam int AXIS_X_BIT = 0;
	localparam int AXIS_Y_BIT = 1;
	localparam int AXIS_Z_BIT = 2;

	typedef struct packed {
		logic signed [FIELD_W-1:0] origin_x;
		logic signed [FIELD_W-1:0] origin_y;
		logic signed [FIELD_W-1:0] origin_z;
		logic [ROT_W-1:0]          rot_x;
		logic [ROT_W-1:0]          rot_y;
		logic [ROT_W-1:0]          rot_z;
		logic [AXIS_W-1:0]         axis_en;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic sat;
		logic last;
	} beat_ctl_t;

endpackage
`default_nettype wire

/* design/prot_cfg.sv */
// configuration register file for the point rotation pipeline
`default_nettype none
module prot_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [prot_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [prot_pkg::ROT_W-1:0]     wr_data,
	output prot_pkg::cfg_t                      cfg
);
	import prot_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.rot_x    <= ROT_RESET;
			cfg_q.rot_y    <= ROT_RESET;
			cfg_q.rot_z    <= ROT_RESET;
			cfg_q.axis_en  <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_ORIGIN_X: cfg_q.origin_x <= wr_data[FIELD_W-1:0];
				REG_ORIGIN_Y: cfg_q.origin_y <= wr_data[FIELD_W-1:0];
				REG_ORIGIN_Z: cfg_q.origin_z <= wr_data[FIELD_W-1:0];
				REG_ROT_X:    cfg_q.rot_x    <= wr_data;
				REG_ROT_Y:    cfg_q.rot_y    <= wr_data;
				REG_ROT_Z:    cfg_q.rot_z    <= wr_data;
				REG_AXIS_EN:  cfg_q.axis_en  <= wr_data[AXIS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/prot_stage.sv */
// four-stage pipelined rotation of one coordinate pair about an origin
`default_nettype none
module prot_stage #(
	parameter int COORD_WIDTH = prot_pkg::COORD_WIDTH_DEF,
	parameter int DW          = (COORD_WIDTH > prot_pkg::FIELD_W) ? COORD_WIDTH
	                                                              : prot_pkg::FIELD_W
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic signed [prot_pkg::FIELD_W-1:0]   org_p,
	input  wire logic signed [prot_pkg::FIELD_W-1:0]   org_q,
	input  wire logic [prot_pkg::ROT_W-1:0]            rot,
	input  wire prot_pkg::beat_ctl_t                   in_ctl,
	input  wire logic signed [DW-1:0]                  in_p,
	input  wire logic signed [DW-1:0]                  in_q,
	input  wire logic signed [DW-1:0]                  in_r,
	output prot_pkg::beat_ctl_t                        out_ctl,
	output logic signed [DW-1:0]                       out_p,
	output logic signed [DW-1:0]                       out_q,
	output logic signed [DW-1:0]                       out_r
);
	import prot_pkg::*;

	localparam int SPLIT = 24;
	localparam int HW    = DW + 1 - SPLIT;
	localparam int HPW   = HW + FIELD_W;
	localparam int LPW   = SPLIT + 1 + FIELD_W;
	localparam int LW    = LPW + 1;
	localparam int TW    = DW + 10;
	localparam int RSH   = 6;

	localparam logic signed [TW-1:0] SAT_MAX =
		{{(TW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [TW-1:0] SAT_MIN = ~SAT_MAX;
	localparam logic signed [TW-1:0] RND     = TW'(32);

	logic signed [FIELD_W-1:0] cos_v, sin_v;
	assign cos_v = rot[ROT_W-1:FIELD_W];
	assign sin_v = rot[FIELD_W-1:0];

	// s1: differences from origin
	beat_ctl_t            ctl_s1;
	logic signed [DW-1:0] p_s1, q_s1, r_s1;
	logic signed [DW:0]   dp_s1, dq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= in_p;
		q_s1  <= in_q;
		r_s1  <= in_r;
		dp_s1 <= (DW+1)'(in_p) - (DW+1)'(org_p);
		dq_s1 <= (DW+1)'(in_q) - (DW+1)'(org_q);
	end

	// s2: split partial products
	logic signed [HW-1:0]  ahp, ahq;
	logic signed [SPLIT:0] alp, alq;
	logic signed [HPW-1:0] hpc, hqs, hps, hqc;
	logic signed [LPW-1:0] lpc, lqs, lps, lqc;

	always_comb begin
		ahp = dp_s1[DW:SPLIT];
		ahq = dq_s1[DW:SPLIT];
		alp = {1'b0, dp_s1[SPLIT-1:0]};
		alq = {1'b0, dq_s1[SPLIT-1:0]};
		hpc = ahp * cos_v;
		hqs = ahq * sin_v;
		hps = ahp * sin_v;
		hqc = ahq * cos_v;
		lpc = alp * cos_v;
		lqs = alq * sin_v;
		lps = alp * sin_v;
		lqc = alq * cos_v;
	end

	beat_ctl_t             ctl_s2;
	logic signed [DW-1:0]  p_s2, q_s2, r_s2;
	logic signed [HPW-1:0] hpc_s2, hqs_s2, hps_s2, hqc_s2;
	logic signed [LPW-1:0] lpc_s2, lqs_s2, lps_s2, lqc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s2   <= p_s1;
		q_s2   <= q_s1;
		r_s2   <= r_s1;
		hpc_s2 <= hpc;
		hqs_s2 <= hqs;
		hps_s2 <= hps;
		hqc_s2 <= hqc;
		lpc_s2 <= lpc;
		lqs_s2 <= lqs;
		lps_s2 <= lps;
		lqc_s2 <= lqc;
	end

	// s3: high and low sums
	beat_ctl_t            ctl_s3;
	logic signed [DW-1:0] p_s3, q_s3, r_s3;
	logic signed [TW-1:0] hi_p_s3, hi_q_s3;
	logic signed [LW-1:0] lo_p_s3, lo_q_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s3    <= p_s2;
		q_s3    <= q_s2;
		r_s3    <= r_s2;
		hi_p_s3 <= TW'(hpc_s2) - TW'(hqs_s2);
		hi_q_s3 <= TW'(hps_s2) + TW'(hqc_s2);
		lo_p_s3 <= LW'(lpc_s2) - LW'(lqs_s2);
		lo_q_s3 <= LW'(lps_s2) + LW'(lqc_s2);
	end

	// s4: when enabled, round, add origin back, clamp; otherwise pass the pair through
	function automatic logic signed [DW-1:0] clamp(input logic signed [TW-1:0] v);
		logic signed [TW-1:0] c;
		c = v;
		if (v > SAT_MAX) c = SAT_MAX;
		if (v < SAT_MIN) c = SAT_MIN;
		return c[DW-1:0];
	endfunction

	logic signed [TW-1:0] t_p, t_q, r_p, r_q;
	logic                 hit_p, hit_q;

	always_comb begin
		t_p   = hi_p_s3 + TW'(lo_p_s3 >>> SPLIT) + RND;
		t_q   = hi_q_s3 + TW'(lo_q_s3 >>> SPLIT) + RND;
		r_p   = (t_p >>> RSH) + TW'(org_p);
		r_q   = (t_q >>> RSH) + TW'(org_q);
		hit_p = (r_p > SAT_MAX) || (r_p < SAT_MIN);
		hit_q = (r_q > SAT_MAX) || (r_q < SAT_MIN);
	end

	beat_ctl_t            ctl_s4;
	logic signed [DW-1:0] p_s4, q_s4, r_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4.valid <= ctl_s3.valid;
			ctl_s4.last  <= ctl_s3.last;
			ctl_s4.sat   <= ctl_s3.sat | (en & (hit_p | hit_q));
		end
	end

	always_ff @(posedge clk) begin
		r_s4 <= r_s3;
		if (en) begin
			p_s4 <= clamp(r_p);
			q_s4 <= clamp(r_q);
		end else begin
			p_s4 <= p_s3;
			q_s4 <= q_s3;
		end
	end

	assign out_ctl = ctl_s4;
	assign out_p   = p_s4;
	assign out_q   = q_s4;
	assign out_r   = r_s4;

endmodule
`default_nettype wire

/* design/point_rotation_about_origin.sv */
// top level: point rotation about a configured origin, x then y then z axis
//
//  channel   handshake                 beat
//  input     start, busy               x_coord y_coord z_coord last_point
//  config    cfg_valid, cfg_ready      cfg_index cfg_data
//  result    done                      x_rotated y_rotated z_rotated saturated last_out
//
//  one point accepted per cycle; busy and cfg_ready are constant
//  done follows start through three rotation units of four stages each
//  reset clears all valid bits and returns the registers to identity, no axes on
//  the receiver takes every result, so nothing in the pipeline ever stalls
`default_nettype none
module point_rotation_about_origin #(
	parameter int COORD_WIDTH = prot_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [prot_pkg::FIELD_W-1:0]   x_coord,
	input  wire logic signed [prot_pkg::FIELD_W-1:0]   y_coord,
	input  wire logic signed [prot_pkg::FIELD_W-1:0]   z_coord,
	input  wire logic                                  last_point,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [prot_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [prot_pkg::ROT_W-1:0]            cfg_data,
	output logic                                       done,
	output logic signed [prot_pkg::FIELD_W-1:0]        x_rotated,
	output logic signed [prot_pkg::FIELD_W-1:0]        y_rotated,
	output logic signed [prot_pkg::FIELD_W-1:0]        z_rotated,
	output logic                                       saturated,
	output logic                                       last_out
);
	import prot_pkg::*;

	localparam int DW = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;

	cfg_t cfg;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	prot_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	beat_ctl_t            ctl_in, ctl_x, ctl_y, ctl_z;
	logic signed [DW-1:0] x_in, y_in, z_in;
	logic signed [DW-1:0] x_a, y_a, z_a;
	logic signed [DW-1:0] x_b, y_b, z_b;
	logic signed [DW-1:0] x_c, y_c, z_c;

	assign ctl_in.valid = start & ~busy;
	assign ctl_in.sat   = 1'b0;
	assign ctl_in.last  = last_point;
	assign x_in         = DW'(x_coord);
	assign y_in         = DW'(y_coord);
	assign z_in         = DW'(z_coord);

	// about x: (y, z)
	prot_stage #(.COORD_WIDTH(COORD_WIDTH), .DW(DW)) u_rot_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (cfg.axis_en[AXIS_X_BIT]),
		.org_p   (cfg.origin_y),
		.org_q   (cfg.origin_z),
		.rot     (cfg.rot_x),
		.in_ctl  (ctl_in),
		.in_p    (y_in),
		.in_q    (z_in),
		.in_r    (x_in),
		.out_ctl (ctl_x),
		.out_p   (y_a),
		.out_q   (z_a),
		.out_r   (x_a)
	);

	// about y: (z, x)
	prot_stage #(.COORD_WIDTH(COORD_WIDTH), .DW(DW)) u_rot_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (cfg.axis_en[AXIS_Y_BIT]),
		.org_p   (cfg.origin_z),
		.org_q   (cfg.origin_x),
		.rot     (cfg.rot_y),
		.in_ctl  (ctl_x),
		.in_p    (z_a),
		.in_q    (x_a),
		.in_r    (y_a),
		.out_ctl (ctl_y),
		.out_p   (z_b),
		.out_q   (x_b),
		.out_r   (y_b)
	);

	// about z: (x, y)
	prot_stage #(.COORD_WIDTH(COORD_WIDTH), .DW(DW)) u_rot_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (cfg.axis_en[AXIS_Z_BIT]),
		.org_p   (cfg.origin_x),
		.org_q   (cfg.origin_y),
		.rot     (cfg.rot_z),
		.in_ctl  (ctl_y),
		.in_p    (x_b),
		.in_q    (y_b),
		.in_r    (z_b),
		.out_ctl (ctl_z),
		.out_p   (x_c),
		.out_q   (y_c),
		.out_r   (z_c)
	);

	assign done      = ctl_z.valid;
	assign saturated = ctl_z.sat;
	assign last_out  = ctl_z.last;
	assign x_rotated = x_c[FIELD_W-1:0];
	assign y_rotated = y_c[FIELD_W-1:0];
	assign z_rotated = z_c[FIELD_W-1:0];

endmodule
`default_nettype wire
